// ===== hw/rtl/aopu_pkg.sv =====
// Shared constants, command codes and types for the arc odometry pose update core.
`timescale 1ns / 1ps
package aopu_pkg;

  localparam int CORDIC_ITERATIONS = 24;
  localparam int DIST_FRAC_BITS    = 16;
  localparam int IDX_W             = 5;

  localparam logic [30:0] MAX_STEP_RESET = 31'(10 << DIST_FRAC_BITS);

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [33:0] INV_GAIN    = 34'sd652032874;

  // configuration register indexes
  localparam logic [2:0] REG_REAR_OFFSET  = 3'd0;
  localparam logic [2:0] REG_RIGHT_OFFSET = 3'd1;
  localparam logic [2:0] REG_MAX_STEP     = 3'd2;
  localparam logic [2:0] REG_START_X      = 3'd3;
  localparam logic [2:0] REG_START_Y      = 3'd4;
  localparam logic [2:0] REG_START_HEAD   = 3'd5;

  // datapath operations
  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_CAPTURE   = 5'd1;
  localparam logic [4:0] OP_LOAD_POSE = 5'd2;
  localparam logic [4:0] OP_REJECT    = 5'd3;
  localparam logic [4:0] OP_STRAIGHT  = 5'd4;
  localparam logic [4:0] OP_ZERO      = 5'd5;
  localparam logic [4:0] OP_RED_D     = 5'd6;
  localparam logic [4:0] OP_RED_H     = 5'd7;
  localparam logic [4:0] OP_FOLD      = 5'd8;
  localparam logic [4:0] OP_ITER      = 5'd9;
  localparam logic [4:0] OP_CORRX     = 5'd10;
  localparam logic [4:0] OP_CORRY     = 5'd11;
  localparam logic [4:0] OP_DIV_INIT  = 5'd12;
  localparam logic [4:0] OP_DIV_STEP  = 5'd13;
  localparam logic [4:0] OP_DIV_END   = 5'd14;
  localparam logic [4:0] OP_WR_LX     = 5'd15;
  localparam logic [4:0] OP_WR_LY     = 5'd16;
  localparam logic [4:0] OP_WR_PX     = 5'd17;
  localparam logic [4:0] OP_WR_PYH    = 5'd18;

  // multiplier operand pairs
  localparam logic [3:0] MS_NONE     = 4'd0;
  localparam logic [3:0] MS_YZ       = 4'd1;
  localparam logic [3:0] MS_XZ       = 4'd2;
  localparam logic [3:0] MS_K_REAR   = 4'd3;
  localparam logic [3:0] MS_S2_ROFF  = 4'd4;
  localparam logic [3:0] MS_K_RIGHT  = 4'd5;
  localparam logic [3:0] MS_S2_RTOFF = 4'd6;
  localparam logic [3:0] MS_LX_C     = 4'd7;
  localparam logic [3:0] MS_LY_S     = 4'd8;
  localparam logic [3:0] MS_LY_C     = 4'd9;
  localparam logic [3:0] MS_LX_S     = 4'd10;

  // accumulator actions
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  typedef struct packed {
    logic [4:0]       op;
    logic [3:0]       mul_sel;
    logic [1:0]       acc_op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic reject;
    logic straight;
    logic zero_turn;
  } status_t;

  typedef struct packed {
    logic signed [31:0] rear_offset;
    logic signed [31:0] right_offset;
    logic [30:0]        max_step;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_heading;
  } cfg_t;

  function automatic logic [31:0] atan_entry(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd843314856;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd67021686;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      5'd20: v = 32'd1023;
      5'd21: v = 32'd511;
      5'd22: v = 32'd255;
      5'd23: v = 32'd127;
      5'd24: v = 32'd63;
      5'd25: v = 32'd31;
      5'd26: v = 32'd15;
      5'd27: v = 32'd7;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/aopu_datapath.sv =====
// Datapath: CORDIC sine/cosine, quotient divider, shared multiplier and pose registers.
`timescale 1ns / 1ps
module aopu_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  aopu_pkg::cmd_t        cmd,
  input  aopu_pkg::cfg_t        cfg,
  input  logic                  in_mode,
  input  logic signed [31:0]    in_left,
  input  logic signed [31:0]    in_right,
  input  logic signed [31:0]    in_rear,
  input  logic signed [31:0]    in_dth,
  output aopu_pkg::status_t     status,
  output logic signed [31:0]    pos_x,
  output logic signed [31:0]    pos_y,
  output logic signed [31:0]    head,
  output logic                  rej
);

  logic               mode;
  logic signed [31:0] left, right, rear, dth;
  logic signed [35:0] z;
  logic signed [33:0] x, y;
  logic               neg;
  logic signed [35:0] cx;
  logic signed [31:0] c_q, s_q;
  logic signed [32:0] s2;
  logic [32:0]        rem;
  logic [30:0]        num_lo, q;
  logic [31:0]        den;
  logic               qneg, ovf;
  logic signed [31:0] k, lx, ly;
  logic signed [67:0] prod;
  logic signed [69:0] acc;

  logic signed [33:0] mul_a, mul_b;
  logic signed [35:0] ang, red, wrapped;
  logic signed [35:0] tval;
  logic signed [35:0] cy;
  logic signed [32:0] s2v;
  logic [32:0]        s2mag, rs;
  logic [30:0]        qm;
  logic signed [69:0] prod_r, acc_r;

  function automatic logic [32:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~{v[31], v} + 33'd1) : {1'b0, v};
  endfunction

  function automatic logic signed [69:0] rnd30(input logic signed [69:0] v);
    return (v + 70'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    if (v > 70'sd2147483647) return 32'sh7fffffff;
    if (v < -70'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic logic signed [31:0] clamp_one(input logic signed [35:0] v);
    if (v > 36'sd1073741824) return 32'sd1073741824;
    if (v < -36'sd1073741824) return -32'sd1073741824;
    return 32'(v);
  endfunction

  assign status.mode      = mode;
  assign status.reject    = (mag32(left) > {2'b00, cfg.max_step}) ||
                            (mag32(right) > {2'b00, cfg.max_step}) ||
                            (mag32(rear) > {2'b00, cfg.max_step});
  assign status.straight  = (left == right);
  assign status.zero_turn = (dth == 32'sd0);

  always_comb begin
    case (cmd.mul_sel)
      aopu_pkg::MS_YZ:       begin mul_a = y;          mul_b = z[33:0];              end
      aopu_pkg::MS_XZ:       begin mul_a = x;          mul_b = z[33:0];              end
      aopu_pkg::MS_K_REAR:   begin mul_a = 34'(k);     mul_b = 34'(rear);            end
      aopu_pkg::MS_S2_ROFF:  begin mul_a = 34'(s2);    mul_b = 34'(cfg.rear_offset); end
      aopu_pkg::MS_K_RIGHT:  begin mul_a = 34'(k);     mul_b = 34'(right);           end
      aopu_pkg::MS_S2_RTOFF: begin mul_a = 34'(s2);    mul_b = 34'(cfg.right_offset); end
      aopu_pkg::MS_LX_C:     begin mul_a = 34'(lx);    mul_b = 34'(c_q);             end
      aopu_pkg::MS_LY_S:     begin mul_a = 34'(ly);    mul_b = 34'(s_q);             end
      aopu_pkg::MS_LY_C:     begin mul_a = 34'(ly);    mul_b = 34'(c_q);             end
      aopu_pkg::MS_LX_S:     begin mul_a = 34'(lx);    mul_b = 34'(s_q);             end
      default:               begin mul_a = '0;         mul_b = '0;                   end
    endcase
  end

  always_comb begin
    // truncating remainder by PI_Q30 (2*pi in Q29), then doubled to a Q30 angle
    ang = (cmd.op == aopu_pkg::OP_RED_H) ? ((36'(head) <<< 1) + 36'(dth)) : 36'(dth);
    if (ang >= aopu_pkg::PI_Q30) red = ang - aopu_pkg::PI_Q30;
    else if (ang <= -aopu_pkg::PI_Q30) red = ang + aopu_pkg::PI_Q30;
    else red = ang;
    if (z > aopu_pkg::PI_Q30) wrapped = z - aopu_pkg::TWO_PI_Q30;
    else if (z < -aopu_pkg::PI_Q30) wrapped = z + aopu_pkg::TWO_PI_Q30;
    else wrapped = z;
    tval   = $signed({4'b0000, aopu_pkg::atan_entry(cmd.idx)});
    prod_r = rnd30(70'(prod));
    acc_r  = rnd30(acc);
    cy     = 36'(70'(y) + prod_r);
    s2v    = {s_q, 1'b0};
    s2mag  = s2v[32] ? (~s2v + 33'd1) : s2v;
    rs     = {rem[31:0], num_lo[30]};
    qm     = (ovf || (q > 31'h40000000)) ? 31'h40000000 : q;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != aopu_pkg::MS_NONE) prod <= mul_a * mul_b;
    case (cmd.acc_op)
      aopu_pkg::ACC_LOAD: acc <= 70'(prod);
      aopu_pkg::ACC_ADD:  acc <= acc + 70'(prod);
      aopu_pkg::ACC_SUB:  acc <= acc - 70'(prod);
      default: ;
    endcase
    case (cmd.op)
      aopu_pkg::OP_CAPTURE: begin
        mode  <= in_mode;
        left  <= in_left;
        right <= in_right;
        rear  <= in_rear;
        dth   <= in_dth;
      end
      aopu_pkg::OP_STRAIGHT: begin
        lx <= rear;
        ly <= left;
      end
      aopu_pkg::OP_ZERO: begin
        lx <= '0;
        ly <= '0;
      end
      aopu_pkg::OP_RED_D, aopu_pkg::OP_RED_H: z <= red <<< 1;
      aopu_pkg::OP_FOLD: begin
        x <= aopu_pkg::INV_GAIN;
        y <= '0;
        if (wrapped > aopu_pkg::HALF_PI_Q30) begin
          z   <= wrapped - aopu_pkg::PI_Q30;
          neg <= 1'b1;
        end else if (wrapped < -aopu_pkg::HALF_PI_Q30) begin
          z   <= wrapped + aopu_pkg::PI_Q30;
          neg <= 1'b1;
        end else begin
          z   <= wrapped;
          neg <= 1'b0;
        end
      end
      aopu_pkg::OP_ITER: begin
        if (z >= 36'sd0) begin
          x <= x - (y >>> cmd.idx);
          y <= y + (x >>> cmd.idx);
          z <= z - tval;
        end else begin
          x <= x + (y >>> cmd.idx);
          y <= y - (x >>> cmd.idx);
          z <= z + tval;
        end
      end
      aopu_pkg::OP_CORRX: cx <= 36'(70'(x) - prod_r);
      aopu_pkg::OP_CORRY: begin
        c_q <= neg ? -clamp_one(cx) : clamp_one(cx);
        s_q <= neg ? -clamp_one(cy) : clamp_one(cy);
      end
      aopu_pkg::OP_DIV_INIT: begin
        s2     <= s2v;
        rem    <= 33'(s2mag >> 3);
        num_lo <= {s2mag[2:0], 28'd0};
        den    <= 32'(mag32(dth));
        ovf    <= (s2mag >> 3) >= mag32(dth);
        qneg   <= s2v[32] ^ dth[31];
        q      <= '0;
      end
      aopu_pkg::OP_DIV_STEP: begin
        num_lo <= {num_lo[29:0], 1'b0};
        if (rs >= {1'b0, den}) begin
          rem <= rs - {1'b0, den};
          q   <= {q[29:0], 1'b1};
        end else begin
          rem <= rs;
          q   <= {q[29:0], 1'b0};
        end
      end
      aopu_pkg::OP_DIV_END: k <= qneg ? -$signed(32'(qm)) : $signed(32'(qm));
      aopu_pkg::OP_WR_LX:   lx <= sat32(acc_r);
      aopu_pkg::OP_WR_LY:   ly <= sat32(acc_r);
      default: ;
    endcase
  end

  // pose and reject flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      head  <= '0;
      rej   <= 1'b0;
    end else begin
      case (cmd.op)
        aopu_pkg::OP_CAPTURE: rej <= 1'b0;
        aopu_pkg::OP_REJECT:  rej <= 1'b1;
        aopu_pkg::OP_LOAD_POSE: begin
          pos_x <= cfg.start_x;
          pos_y <= cfg.start_y;
          head  <= cfg.start_heading;
        end
        aopu_pkg::OP_WR_PX: pos_x <= sat32(70'(pos_x) + acc_r);
        aopu_pkg::OP_WR_PYH: begin
          pos_y <= sat32(70'(pos_y) + acc_r);
          head  <= sat32(70'(head) + 70'(dth));
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/aopu_controller.sv =====
// Controller: sequences capture, sine/cosine, division, arc offset and rotation.
`timescale 1ns / 1ps
module aopu_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_free,
  input  aopu_pkg::status_t status,
  output logic              in_ready,
  output logic              publish,
  output aopu_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_RED   = 4'd2;
  localparam logic [3:0] S_FOLD  = 4'd3;
  localparam logic [3:0] S_ITER  = 4'd4;
  localparam logic [3:0] S_MULYZ = 4'd5;
  localparam logic [3:0] S_CORRX = 4'd6;
  localparam logic [3:0] S_CORRY = 4'd7;
  localparam logic [3:0] S_DIVI  = 4'd8;
  localparam logic [3:0] S_DIVS  = 4'd9;
  localparam logic [3:0] S_DIVE  = 4'd10;
  localparam logic [3:0] S_ARC   = 4'd11;
  localparam logic [3:0] S_ROT   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  localparam logic [aopu_pkg::IDX_W-1:0] ITER_LAST =
    aopu_pkg::IDX_W'(aopu_pkg::CORDIC_ITERATIONS - 1);
  localparam logic [aopu_pkg::IDX_W-1:0] DIV_LAST  = aopu_pkg::IDX_W'(30);
  localparam logic [aopu_pkg::IDX_W-1:0] SEQ_LAST  = aopu_pkg::IDX_W'(5);

  logic [3:0]                   state, state_next;
  logic [aopu_pkg::IDX_W-1:0]   cnt, cnt_next;
  logic                         second, second_next;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    second_next = second;
    in_ready    = 1'b0;
    publish     = 1'b0;
    cmd         = '{op: aopu_pkg::OP_NONE, mul_sel: aopu_pkg::MS_NONE,
                    acc_op: aopu_pkg::ACC_NONE, idx: cnt};
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = aopu_pkg::OP_CAPTURE;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.mode) begin
          cmd.op     = aopu_pkg::OP_LOAD_POSE;
          state_next = S_OUT;
        end else if (status.reject) begin
          cmd.op     = aopu_pkg::OP_REJECT;
          state_next = S_OUT;
        end else if (status.straight) begin
          cmd.op      = aopu_pkg::OP_STRAIGHT;
          second_next = 1'b1;
          state_next  = S_RED;
        end else if (status.zero_turn) begin
          cmd.op      = aopu_pkg::OP_ZERO;
          second_next = 1'b1;
          state_next  = S_RED;
        end else begin
          second_next = 1'b0;
          state_next  = S_RED;
        end
      end
      S_RED: begin
        cmd.op     = second ? aopu_pkg::OP_RED_H : aopu_pkg::OP_RED_D;
        state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.op     = aopu_pkg::OP_FOLD;
        cnt_next   = '0;
        state_next = S_ITER;
      end
      S_ITER: begin
        cmd.op = aopu_pkg::OP_ITER;
        if (cnt == ITER_LAST) state_next = S_MULYZ;
        else cnt_next = cnt + 1'b1;
      end
      S_MULYZ: begin
        cmd.mul_sel = aopu_pkg::MS_YZ;
        state_next  = S_CORRX;
      end
      S_CORRX: begin
        cmd.op      = aopu_pkg::OP_CORRX;
        cmd.mul_sel = aopu_pkg::MS_XZ;
        state_next  = S_CORRY;
      end
      S_CORRY: begin
        cmd.op     = aopu_pkg::OP_CORRY;
        cnt_next   = '0;
        state_next = second ? S_ROT : S_DIVI;
      end
      S_DIVI: begin
        cmd.op     = aopu_pkg::OP_DIV_INIT;
        cnt_next   = '0;
        state_next = S_DIVS;
      end
      S_DIVS: begin
        cmd.op = aopu_pkg::OP_DIV_STEP;
        if (cnt == DIV_LAST) state_next = S_DIVE;
        else cnt_next = cnt + 1'b1;
      end
      S_DIVE: begin
        cmd.op     = aopu_pkg::OP_DIV_END;
        cnt_next   = '0;
        state_next = S_ARC;
      end
      S_ARC: begin
        // lx = k*rear + s2*rear_off, then ly = k*right + s2*right_off
        case (cnt)
          5'd0: cmd.mul_sel = aopu_pkg::MS_K_REAR;
          5'd1: begin
            cmd.mul_sel = aopu_pkg::MS_S2_ROFF;
            cmd.acc_op  = aopu_pkg::ACC_LOAD;
          end
          5'd2: begin
            cmd.mul_sel = aopu_pkg::MS_K_RIGHT;
            cmd.acc_op  = aopu_pkg::ACC_ADD;
          end
          5'd3: begin
            cmd.op      = aopu_pkg::OP_WR_LX;
            cmd.mul_sel = aopu_pkg::MS_S2_RTOFF;
            cmd.acc_op  = aopu_pkg::ACC_LOAD;
          end
          5'd4: cmd.acc_op = aopu_pkg::ACC_ADD;
          default: cmd.op = aopu_pkg::OP_WR_LY;
        endcase
        if (cnt == SEQ_LAST) begin
          second_next = 1'b1;
          state_next  = S_RED;
        end else cnt_next = cnt + 1'b1;
      end
      S_ROT: begin
        // x += lx*c + ly*s, y += ly*c - lx*s
        case (cnt)
          5'd0: cmd.mul_sel = aopu_pkg::MS_LX_C;
          5'd1: begin
            cmd.mul_sel = aopu_pkg::MS_LY_S;
            cmd.acc_op  = aopu_pkg::ACC_LOAD;
          end
          5'd2: begin
            cmd.mul_sel = aopu_pkg::MS_LY_C;
            cmd.acc_op  = aopu_pkg::ACC_ADD;
          end
          5'd3: begin
            cmd.op      = aopu_pkg::OP_WR_PX;
            cmd.mul_sel = aopu_pkg::MS_LX_S;
            cmd.acc_op  = aopu_pkg::ACC_LOAD;
          end
          5'd4: cmd.acc_op = aopu_pkg::ACC_SUB;
          default: cmd.op = aopu_pkg::OP_WR_PYH;
        endcase
        if (cnt == SEQ_LAST) state_next = S_OUT;
        else cnt_next = cnt + 1'b1;
      end
      S_OUT: begin
        // hold until the result register can take the new pose
        if (out_free) begin
          publish    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      second <= second_next;
    end
  end

endmodule

// ===== hw/rtl/arc_odometry_pose_update_core.sv =====
// Top level: stream ports, configuration registers, result register, controller and datapath.
//
//  channel   direction  signals                        contents
//  s_axis    in         tvalid tready tdata tuser      tick deltas, tuser = mode
//  m_axis    out        tvalid tready tdata tuser      pose, tuser = rejected
//  cfg       in         cfg_valid cfg_ready index data register writes
//
// A pose load or a rejected tick goes from transfer to result through the check and output
// states only; a straight or zero-turn tick also takes one pass of the 24-step CORDIC unit;
// an arc tick takes two passes of it and one of the 31-step quotient divider, one step per cycle.
// Reset clears the pose, the registers and the handshake state; no clearing pass.
// A waiting result does not stop the next transfer in; the next result waits for it.
`timescale 1ns / 1ps
module arc_odometry_pose_update_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // left_travel, right_travel, rear_travel, heading_change
  input  logic         s_axis_tuser,   // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // pos_x, pos_y, heading
  output logic         m_axis_tuser,   // rejected
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  aopu_pkg::cfg_t    cfg;
  aopu_pkg::cmd_t    cmd;
  aopu_pkg::status_t status;
  logic              publish, out_free;
  logic signed [31:0] pos_x, pos_y, head;
  logic              rej;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rear_offset   <= '0;
      cfg.right_offset  <= '0;
      cfg.max_step      <= aopu_pkg::MAX_STEP_RESET;
      cfg.start_x       <= '0;
      cfg.start_y       <= '0;
      cfg.start_heading <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        aopu_pkg::REG_REAR_OFFSET:  cfg.rear_offset   <= cfg_data;
        aopu_pkg::REG_RIGHT_OFFSET: cfg.right_offset  <= cfg_data;
        aopu_pkg::REG_MAX_STEP:     cfg.max_step      <= cfg_data[30:0];
        aopu_pkg::REG_START_X:      cfg.start_x       <= cfg_data;
        aopu_pkg::REG_START_Y:      cfg.start_y       <= cfg_data;
        aopu_pkg::REG_START_HEAD:   cfg.start_heading <= cfg_data;
        default: ;
      endcase
    end
  end

  aopu_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .out_free (out_free),
    .status   (status),
    .in_ready (s_axis_tready),
    .publish  (publish),
    .cmd      (cmd)
  );

  aopu_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_mode  (s_axis_tuser),
    .in_left  (s_axis_tdata[31:0]),
    .in_right (s_axis_tdata[63:32]),
    .in_rear  (s_axis_tdata[95:64]),
    .in_dth   (s_axis_tdata[127:96]),
    .status   (status),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .head     (head),
    .rej      (rej)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (publish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      m_axis_tdata <= {head, pos_y, pos_x};
      m_axis_tuser <= rej;
    end
  end

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !publish)
    else $error("result overwritten while stalled");

  // no transfer in during the cycle in which a result is published
  a_no_accept_on_publish: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> !publish)
    else $error("input taken during publish");

  // a rejected tick leaves the heading and pos_x alone
  a_reject_keeps_pose: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == aopu_pkg::OP_REJECT) |=> $stable(head) && $stable(pos_x))
    else $error("pose moved on rejected tick");

endmodule

// ===== tb/sv/pose_checker.sv =====
// Checker: watches the stream and config channels, predicts the pose and compares results.
`timescale 1ns / 1ps
module pose_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // left_travel, right_travel, rear_travel, heading_change
  input  logic         s_axis_tuser,   // mode
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,   // pos_x, pos_y, heading
  input  logic         m_axis_tuser,   // rejected
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  localparam longint ONE_Q30   = 64'sd1073741824;
  localparam longint PI_RAD    = 64'sd3373259426;
  localparam longint HALF_PI   = 64'sd1686629713;
  localparam longint CORDIC_K  = 64'sd652032874;
  localparam longint HALF_LSB  = 64'sd536870912;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] h;
    logic               rej;
  } pose_t;

  pose_t expected_pose[$];

  longint arctan_q30[30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 7, 3, 1
  };

  logic signed [31:0] rear_off, right_off, home_x, home_y, home_h;
  logic [30:0]        step_limit;
  logic signed [31:0] cur_x, cur_y, cur_h;

  function automatic longint round_q30(longint v);
    return (v + HALF_LSB) >>> 30;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  // angle in Q29 radians, cosine and sine in Q30
  task automatic trig(input longint ang, output longint c, output longint s);
    longint z, x, y, nx, ny;
    bit flip;
    z = (ang % PI_RAD) * 2;
    x = CORDIC_K;
    y = 0;
    flip = 0;
    if (z > PI_RAD) z -= 2 * PI_RAD;
    if (z < -PI_RAD) z += 2 * PI_RAD;
    if (z > HALF_PI) begin
      z -= PI_RAD; flip = 1;
    end else if (z < -HALF_PI) begin
      z += PI_RAD; flip = 1;
    end
    for (int i = 0; i < aopu_pkg::CORDIC_ITERATIONS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= arctan_q30[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += arctan_q30[i];
      end
      x = nx; y = ny;
    end
    nx = x - round_q30(y * z);
    ny = y + round_q30(x * z);
    x = clamp_unit(nx);
    y = clamp_unit(ny);
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic advance_pose(input logic mode, input logic [127:0] d, output pose_t p);
    longint lt, rt, bk, dth, lim, lx, ly, c, s, s2, k;
    lt  = longint'($signed(d[31:0]));
    rt  = longint'($signed(d[63:32]));
    bk  = longint'($signed(d[95:64]));
    dth = longint'($signed(d[127:96]));
    lim = longint'(step_limit);
    p.rej = 0;
    if (mode) begin
      cur_x = home_x; cur_y = home_y; cur_h = home_h;
    end else if ((lt < 0 ? -lt : lt) > lim || (rt < 0 ? -rt : rt) > lim ||
                 (bk < 0 ? -bk : bk) > lim) begin
      p.rej = 1;
    end else begin
      if (lt == rt) begin
        lx = bk; ly = lt;
      end else if (dth == 0) begin
        lx = 0; ly = 0;
      end else begin
        trig(dth, c, s);
        s2 = 2 * s;
        k  = clamp_unit((s2 * (64'sd1 << 28)) / dth);
        lx = sat_word(round_q30(k * bk + s2 * longint'(rear_off)));
        ly = sat_word(round_q30(k * rt + s2 * longint'(right_off)));
      end
      trig(2 * longint'(cur_h) + dth, c, s);
      cur_x = 32'(sat_word(longint'(cur_x) + round_q30(lx * c + ly * s)));
      cur_y = 32'(sat_word(longint'(cur_y) + round_q30(ly * c - lx * s)));
      cur_h = 32'(sat_word(longint'(cur_h) + dth));
    end
    p.x = cur_x; p.y = cur_y; p.h = cur_h;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pose_t got, want;
    if (rst) begin
      rear_off <= 0; right_off <= 0; step_limit <= aopu_pkg::MAX_STEP_RESET;
      home_x <= 0; home_y <= 0; home_h <= 0;
      cur_x = 0; cur_y = 0; cur_h = 0;
      expected_pose.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[31:0];
        got.y = m_axis_tdata[63:32];
        got.h = m_axis_tdata[95:64];
        got.rej = m_axis_tuser;
        if (expected_pose.size() == 0) begin
          report("unexpected result x", got.x, 32'h0);
        end else begin
          want = expected_pose.pop_front();
          if (got.x !== want.x) report("pos_x", got.x, want.x);
          if (got.y !== want.y) report("pos_y", got.y, want.y);
          if (got.h !== want.h) report("heading", got.h, want.h);
          if (got.rej !== want.rej) report("rejected", 32'(got.rej), 32'(want.rej));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_pose(s_axis_tuser, s_axis_tdata, want);
        expected_pose.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aopu_pkg::REG_REAR_OFFSET:  rear_off   <= cfg_data;
          aopu_pkg::REG_RIGHT_OFFSET: right_off  <= cfg_data;
          aopu_pkg::REG_MAX_STEP:     step_limit <= cfg_data[30:0];
          aopu_pkg::REG_START_X:      home_x     <= cfg_data;
          aopu_pkg::REG_START_Y:      home_y     <= cfg_data;
          aopu_pkg::REG_START_HEAD:   home_h     <= cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_pose.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top: clock, reset, stimulus for the pose update core and the final verdict.
`timescale 1ns / 1ps
module testbench;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  int           fail_count, pending;
  int           send_idle_pct = 17;
  int           recv_idle_pct = 75;
  logic [31:0]  step_max = 32'd655360;

  localparam int ARC_LATENCY = 150;

  arc_odometry_pose_update_core u_dut (.*);

  pose_checker u_checker (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  initial begin
    #200_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  task automatic send_tick(input logic mode, input logic [31:0] lt, input logic [31:0] rt,
                           input logic [31:0] bk, input logic [31:0] dth);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {dth, bk, rt, lt};
    forever begin
      @(negedge clk);
      if (s_axis_tready) break;
    end
    @(posedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (ARC_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
    if (idx == aopu_pkg::REG_MAX_STEP) step_max = {1'b0, val[30:0]};
  endtask

  task automatic load_setup(input logic [31:0] roff, input logic [31:0] rtoff,
                            input logic [31:0] lim, input logic [31:0] hx,
                            input logic [31:0] hy, input logic [31:0] hh);
    drain_results();
    write_reg(aopu_pkg::REG_REAR_OFFSET, roff);
    write_reg(aopu_pkg::REG_RIGHT_OFFSET, rtoff);
    write_reg(aopu_pkg::REG_MAX_STEP, lim);
    write_reg(aopu_pkg::REG_START_X, hx);
    write_reg(aopu_pkg::REG_START_Y, hy);
    write_reg(aopu_pkg::REG_START_HEAD, hh);
  endtask

  function automatic logic [31:0] pick_travel();
    logic [31:0] mag;
    case ($urandom_range(19))
      0:       return $urandom;
      1:       return $urandom_range(1) ? step_max : -step_max;
      2:       return $urandom_range(1) ? step_max + 1 : -(step_max + 1);
      default: begin
        mag = $urandom_range(step_max);
        return $urandom_range(1) ? mag : -mag;
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_turn();
    logic [31:0] mag;
    case ($urandom_range(19))
      0:       return $urandom;
      1:       return 32'd0;
      default: begin
        mag = $urandom_range(32'h2000_0000);
        return $urandom_range(1) ? mag : -mag;
      end
    endcase
  endfunction

  task automatic random_ticks(input int count);
    logic [31:0] lt, rt, bk, dth;
    for (int n = 0; n < count; n++) begin
      lt = pick_travel();
      rt = ($urandom_range(9) == 0) ? lt : pick_travel();
      bk = pick_travel();
      dth = pick_turn();
      send_tick($urandom_range(24) == 0, lt, rt, bk, dth);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: pose load, rejects on each wheel, straight, zero turn, arc
    send_tick(1, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
    send_tick(0, 32'd655361, 0, 0, 32'h0100_0000);
    send_tick(0, 0, -32'd655361, 0, 32'h0100_0000);
    send_tick(0, 0, 0, 32'd655361, 32'h0100_0000);
    send_tick(0, 32'd65536, 32'd65536, 32'd32768, 32'h0100_0000);
    send_tick(0, 32'd65536, 32'd131072, 32'd0, 32'd0);
    send_tick(0, 32'd655360, -32'd655360, 32'd655360, 32'h1000_0000);
    send_tick(0, -32'd1000, 32'd2000, -32'd3000, 32'hF000_0000);

    load_setup(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_0000, 32'h8000_0000, 32'h8000_0000);
    send_tick(1, 0, 0, 0, 0);
    send_tick(0, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
    send_tick(0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(0, 32'h1, 32'h0, 32'h7FFF_FFFF, 32'h1);
    send_tick(0, 32'h0, 32'h1, 32'h0, 32'hFFFF_FFFF);
    load_setup(0, 0, 0, 0, 0, 0);
    send_tick(0, 0, 0, 0, 32'h0100_0000);
    send_tick(0, 1, 0, 0, 32'h0100_0000);

    // random phases across settings and idling profiles
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 75; recv_idle_pct = 17;
      end else if (phase == 4) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      case (phase)
        0: load_setup(0, 0, 32'd655360, 0, 0, 0);
        1: load_setup($urandom, $urandom, $urandom_range(32'h7FFF_FFFF), $urandom,
                      $urandom, $urandom);
        2: load_setup($urandom_range(32'h0010_0000), -$urandom_range(32'h0010_0000),
                      32'd6553600, 32'h0001_0000, -32'h0001_0000, 32'h3243_F6A8);
        3: load_setup(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        4: load_setup($urandom, $urandom, $urandom_range(32'h00FF_FFFF), $urandom,
                      $urandom, $urandom);
        default: load_setup(32'h0000_8000, -32'h0000_8000, 32'h0100_0000, 0, 0, 0);
      endcase
      random_ticks(280);
    end

    drain_results();
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
